// ===== rtl/mhc_pkg.sv =====
package mhc_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CSW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	localparam int DIV_NW = 37;
	localparam int DIV_DW = 25;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	localparam int CW = 36;
	localparam int ZW = 27;

	localparam logic [23:0] TRACK_INIT = 24'd2560000;
	localparam logic [24:0] FULL_TURN = 25'd23592960;
	localparam logic [24:0] HALF_TURN = 25'd11796480;
	localparam logic [15:0] SCALE_ONE = 16'd4096;
	localparam logic [15:0] SCALE_MAX = 16'hFFFF;
	localparam logic [15:0] CENTIDEG_TURN = 16'd36000;

	localparam logic [2:0] ACT_MEASURE = 3'd0;
	localparam logic [2:0] ACT_CLEAR = 3'd1;
	localparam logic [2:0] ACT_SAMPLE = 3'd2;
	localparam logic [2:0] ACT_FINISH = 3'd3;
	localparam logic [2:0] ACT_LOAD = 3'd4;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		logic signed [15:0] raw_z;
		logic signed [23:0] load_offset_x;
		logic signed [23:0] load_offset_y;
		logic signed [23:0] load_offset_z;
	} in_t;

	typedef struct packed {
		logic result_kind;
		logic signed [23:0] field_x;
		logic signed [23:0] field_y;
		logic signed [23:0] field_z;
		logic [15:0] heading_centideg;
	} out_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CAPTURE,
		DP_DIV_CONV,
		DP_SAVE_CONV,
		DP_TRACK,
		DP_CLEAR,
		DP_LOAD_OFS,
		DP_MUL,
		DP_RND,
		DP_CORD_INIT,
		DP_CORD_STEP,
		DP_CORD_WRAP,
		DP_CORD_HEAD,
		DP_FIN,
		DP_DIV_SCALE,
		DP_SAVE_SCALE,
		DP_EMIT
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CONV_GO,
		ST_CONV_WAIT,
		ST_TRACK,
		ST_MUL,
		ST_RND,
		ST_CORD_INIT,
		ST_CORD_STEP,
		ST_CORD_WRAP,
		ST_CORD_HEAD,
		ST_FIN,
		ST_SCALE_GO,
		ST_SCALE_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic div_done;
		logic cord_last;
	} stat_t;

	function automatic logic [10:0] lsb_xy(input logic [2:0] code);
		logic [10:0] r;
		unique case (code)
			3'd0: r = 11'd1100;
			3'd1: r = 11'd1100;
			3'd2: r = 11'd855;
			3'd3: r = 11'd670;
			3'd4: r = 11'd450;
			3'd5: r = 11'd400;
			3'd6: r = 11'd330;
			default: r = 11'd230;
		endcase
		return r;
	endfunction

	function automatic logic [10:0] lsb_z(input logic [2:0] code);
		logic [10:0] r;
		unique case (code)
			3'd0: r = 11'd980;
			3'd1: r = 11'd980;
			3'd2: r = 11'd760;
			3'd3: r = 11'd600;
			3'd4: r = 11'd400;
			3'd5: r = 11'd255;
			3'd6: r = 11'd295;
			default: r = 11'd205;
		endcase
		return r;
	endfunction

	function automatic logic [21:0] atan_val(input logic [4:0] i);
		logic [21:0] r;
		unique case (i)
			5'd0: r = 22'd2949120;
			5'd1: r = 22'd1740967;
			5'd2: r = 22'd919879;
			5'd3: r = 22'd466945;
			5'd4: r = 22'd234379;
			5'd5: r = 22'd117304;
			5'd6: r = 22'd58666;
			5'd7: r = 22'd29335;
			5'd8: r = 22'd14668;
			5'd9: r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			5'd22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/mhc_div.sv =====
module mhc_div
	import mhc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIV_NW-1:0] num,
	input logic [DIV_DW-1:0] den,
	output logic [DIV_NW-1:0] quo,
	output logic done
);

	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic done_q;
	logic [DIV_DW:0] rem_sh;
	logic take;

	always_comb begin
		rem_sh = {rem_q, num_q[DIV_NW-1]};
		take = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= DIV_CW'(DIV_NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CW'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[DIV_NW-2:0], take};
			rem_q <= take ? DIV_DW'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DW-1:0];
		end
	end

	assign quo = num_q;
	assign done = done_q;

endmodule

// ===== rtl/mhc_ctrl.sv =====
module mhc_ctrl
	import mhc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input stat_t stat,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [1:0] axis_q;
	logic out_valid_q;
	logic emit;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (stat.action == ACT_MEASURE || stat.action == ACT_SAMPLE) begin
					state_d = ST_CONV_GO;
				end else if (stat.action == ACT_FINISH) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CONV_GO: state_d = ST_CONV_WAIT;
			ST_CONV_WAIT: begin
				if (stat.div_done) begin
					if (axis_q != AX_Z) begin
						state_d = ST_CONV_GO;
					end else if (stat.action == ACT_SAMPLE) begin
						state_d = ST_TRACK;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_TRACK: state_d = ST_DONE;
			ST_MUL: state_d = ST_RND;
			ST_RND: state_d = (axis_q == AX_Z) ? ST_CORD_INIT : ST_MUL;
			ST_CORD_INIT: state_d = ST_CORD_STEP;
			ST_CORD_STEP: if (stat.cord_last) state_d = ST_CORD_WRAP;
			ST_CORD_WRAP: state_d = ST_CORD_HEAD;
			ST_CORD_HEAD: state_d = ST_DONE;
			ST_FIN: state_d = ST_SCALE_GO;
			ST_SCALE_GO: state_d = ST_SCALE_WAIT;
			ST_SCALE_WAIT: begin
				if (stat.div_done) begin
					state_d = (axis_q == AX_Y) ? ST_DONE : ST_SCALE_GO;
				end
			end
			ST_DONE: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = DP_NOP;
		cmd.axis = axis_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) cmd.op = DP_CAPTURE;
			ST_EXEC: begin
				if (stat.action == ACT_CLEAR) begin
					cmd.op = DP_CLEAR;
				end else if (stat.action == ACT_LOAD) begin
					cmd.op = DP_LOAD_OFS;
				end
			end
			ST_CONV_GO: cmd.op = DP_DIV_CONV;
			ST_CONV_WAIT: if (stat.div_done) cmd.op = DP_SAVE_CONV;
			ST_TRACK: cmd.op = DP_TRACK;
			ST_MUL: cmd.op = DP_MUL;
			ST_RND: cmd.op = DP_RND;
			ST_CORD_INIT: cmd.op = DP_CORD_INIT;
			ST_CORD_STEP: cmd.op = DP_CORD_STEP;
			ST_CORD_WRAP: cmd.op = DP_CORD_WRAP;
			ST_CORD_HEAD: cmd.op = DP_CORD_HEAD;
			ST_FIN: cmd.op = DP_FIN;
			ST_SCALE_GO: cmd.op = DP_DIV_SCALE;
			ST_SCALE_WAIT: if (stat.div_done) cmd.op = DP_SAVE_SCALE;
			ST_DONE: if (!out_valid_q || out_ready) cmd.op = DP_EMIT;
			default: cmd.op = DP_NOP;
		endcase
	end

	assign emit = (cmd.op == DP_EMIT);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= AX_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				axis_q <= AX_X;
			end else if (state_q == ST_RND && axis_q != AX_Z) begin
				axis_q <= axis_q + 1'b1;
			end else if (state_q == ST_RND) begin
				axis_q <= AX_X;
			end else if ((state_q == ST_CONV_WAIT || state_q == ST_SCALE_WAIT)
					&& stat.div_done) begin
				axis_q <= (axis_q == AX_Z) ? AX_X : axis_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/mhc_datapath.sv =====
module mhc_datapath
	import mhc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_data,
	input in_t in_data,
	input cmd_t cmd,
	output stat_t stat,
	output out_t out_data
);

	in_t in_q;
	logic [2:0] gain_q;
	logic signed [23:0] v_q [3];
	logic signed [23:0] off_q [3];
	logic [15:0] scale_q [3];
	logic signed [23:0] min_q [3];
	logic signed [23:0] max_q [3];
	logic signed [23:0] f_q [3];
	logic signed [41:0] p_q;
	logic [23:0] dx_q, dy_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [CSW-1:0] cidx_q;
	logic [24:0] zw_q;
	logic [15:0] head_q;
	out_t out_q;

	logic div_start, div_done;
	logic [DIV_NW-1:0] div_num, div_quo;
	logic [DIV_DW-1:0] div_den;

	logic signed [15:0] raw_sel;
	logic [16:0] raw_mag;
	logic [10:0] lsb;
	logic [31:0] conv_num;
	logic signed [23:0] conv_v;

	logic [23:0] sd, so;
	logic [24:0] span_sum;
	logic [DIV_NW-1:0] scale_num;
	logic [15:0] scale_new;

	logic signed [24:0] mdiff;
	logic [41:0] pmag;
	logic [29:0] prnd;
	logic signed [30:0] psgn;
	logic signed [23:0] fsat;

	logic signed [CW-1:0] xi, xs, ys;
	logic signed [ZW-1:0] at;
	logic signed [ZW-1:0] zt;
	logic [31:0] zprod;
	logic [32:0] zrnd;
	logic [16:0] cd;

	mhc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.quo(div_quo),
		.done(div_done)
	);

	always_comb begin
		unique case (cmd.axis)
			AX_X: raw_sel = in_q.raw_x;
			AX_Y: raw_sel = in_q.raw_y;
			default: raw_sel = in_q.raw_z;
		endcase
		lsb = (cmd.axis == AX_Z) ? lsb_z(gain_q) : lsb_xy(gain_q);
		raw_mag = raw_sel[15] ? 17'(-$signed({raw_sel[15], raw_sel}))
			: {1'b0, raw_sel};
		conv_num = 32'(raw_mag) * 32'd25600 + 32'(lsb >> 1);
		conv_v = raw_sel[15] ? -$signed({1'b0, div_quo[22:0]})
			: $signed({1'b0, div_quo[22:0]});

		sd = (cmd.axis == AX_X) ? dx_q : dy_q;
		so = (cmd.axis == AX_X) ? dy_q : dx_q;
		span_sum = {1'b0, sd} + {1'b0, so};
		scale_num = {span_sum, 12'b0} + DIV_NW'(sd);
		if (sd == '0 || div_quo > DIV_NW'(SCALE_MAX)) begin
			scale_new = SCALE_MAX;
		end else begin
			scale_new = div_quo[15:0];
		end

		div_start = (cmd.op == DP_DIV_CONV) || (cmd.op == DP_DIV_SCALE);
		div_num = (cmd.op == DP_DIV_SCALE) ? scale_num : DIV_NW'(conv_num);
		div_den = (cmd.op == DP_DIV_SCALE) ? {sd, 1'b0} : DIV_DW'(lsb);

		mdiff = $signed({v_q[cmd.axis][23], v_q[cmd.axis]})
			- $signed({off_q[cmd.axis][23], off_q[cmd.axis]});
		pmag = p_q[41] ? 42'(-p_q) : 42'(p_q);
		prnd = 30'((pmag + 42'd2048) >> 12);
		psgn = p_q[41] ? -$signed({1'b0, prnd}) : $signed({1'b0, prnd});
		if (psgn > 31'sd8388607) begin
			fsat = 24'sh7FFFFF;
		end else if (psgn < -31'sd8388608) begin
			fsat = -24'sh800000;
		end else begin
			fsat = psgn[23:0];
		end

		xi = $signed({{(CW-32){f_q[0][23]}}, f_q[0], 8'b0});
		xs = cx_q >>> cidx_q;
		ys = cy_q >>> cidx_q;
		at = $signed({5'b0, atan_val(5'(cidx_q))});
		if (cz_q[ZW-1]) begin
			zt = cz_q + $signed({2'b0, FULL_TURN});
		end else if (cz_q >= $signed({2'b0, FULL_TURN})) begin
			zt = cz_q - $signed({2'b0, FULL_TURN});
		end else begin
			zt = cz_q;
		end
		zprod = 32'(zw_q) * 32'd100;
		zrnd = 33'(zprod) + 33'd32768;
		cd = zrnd[32:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 3'd1;
			for (int k = 0; k < 3; k++) begin
				off_q[k] <= '0;
				scale_q[k] <= SCALE_ONE;
				min_q[k] <= $signed(TRACK_INIT);
				max_q[k] <= -$signed(TRACK_INIT);
			end
		end else begin
			if (cfg_we) begin
				gain_q <= cfg_data;
			end
			unique case (cmd.op)
				DP_CLEAR: begin
					for (int k = 0; k < 3; k++) begin
						min_q[k] <= $signed(TRACK_INIT);
						max_q[k] <= -$signed(TRACK_INIT);
					end
				end
				DP_TRACK: begin
					for (int k = 0; k < 3; k++) begin
						if (v_q[k] < min_q[k]) min_q[k] <= v_q[k];
						if (v_q[k] > max_q[k]) max_q[k] <= v_q[k];
					end
				end
				DP_LOAD_OFS: begin
					off_q[0] <= in_q.load_offset_x;
					off_q[1] <= in_q.load_offset_y;
					off_q[2] <= in_q.load_offset_z;
				end
				DP_FIN: begin
					for (int k = 0; k < 3; k++) begin
						off_q[k] <= 24'(($signed({max_q[k][23], max_q[k]})
							+ $signed({min_q[k][23], min_q[k]})) >>> 1);
					end
					scale_q[2] <= SCALE_ONE;
				end
				DP_SAVE_SCALE: scale_q[cmd.axis] <= scale_new;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_CAPTURE: in_q <= in_data;
			DP_SAVE_CONV: v_q[cmd.axis] <= conv_v;
			DP_MUL: p_q <= 42'(mdiff) * 42'($signed({1'b0, scale_q[cmd.axis]}));
			DP_RND: f_q[cmd.axis] <= fsat;
			DP_FIN: begin
				dx_q <= ($signed({max_q[0][23], max_q[0]})
					- $signed({min_q[0][23], min_q[0]})) < 0 ? '0
					: 24'($signed({max_q[0][23], max_q[0]})
					- $signed({min_q[0][23], min_q[0]}));
				dy_q <= ($signed({max_q[1][23], max_q[1]})
					- $signed({min_q[1][23], min_q[1]})) < 0 ? '0
					: 24'($signed({max_q[1][23], max_q[1]})
					- $signed({min_q[1][23], min_q[1]}));
			end
			DP_CORD_INIT: begin
				cidx_q <= '0;
				if (f_q[0][23]) begin
					cx_q <= -xi;
					cy_q <= -$signed({{(CW-32){f_q[1][23]}}, f_q[1], 8'b0});
					cz_q <= $signed({2'b0, HALF_TURN});
				end else begin
					cx_q <= xi;
					cy_q <= $signed({{(CW-32){f_q[1][23]}}, f_q[1], 8'b0});
					cz_q <= '0;
				end
			end
			DP_CORD_STEP: begin
				cidx_q <= cidx_q + 1'b1;
				if (cy_q > 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end
			end
			DP_CORD_WRAP: zw_q <= zt[24:0];
			DP_CORD_HEAD: begin
				if (f_q[0] == '0 && f_q[1] == '0) begin
					head_q <= '0;
				end else if (cd >= 17'(CENTIDEG_TURN)) begin
					head_q <= 16'(cd - 17'(CENTIDEG_TURN));
				end else begin
					head_q <= cd[15:0];
				end
			end
			DP_EMIT: begin
				if (in_q.action == ACT_MEASURE) begin
					out_q.result_kind <= 1'b0;
					out_q.field_x <= f_q[0];
					out_q.field_y <= f_q[1];
					out_q.field_z <= f_q[2];
					out_q.heading_centideg <= head_q;
				end else begin
					out_q <= '{result_kind: 1'b1, default: '0};
				end
			end
			default: ;
		endcase
	end

	assign stat.action = in_q.action;
	assign stat.div_done = div_done;
	assign stat.cord_last = (cidx_q == CSW'(CORDIC_STEPS - 1));
	assign out_data = out_q;

endmodule

// ===== rtl/magnetometer_heading_calibrator_unit.sv =====
// Compass heading unit with hard- and soft-iron calibration. One item is
// handled at a time; a result waits in an output register so the next item
// can be taken meanwhile. Before the next beat is taken, an item also waits
// while the previous result still waits on out_ready. The time per item is
// set by the shared one-bit-per-cycle divider (37 steps per division: one
// per axis conversion, one per X/Y scale) and by the CORDIC_STEPS iterations
// of the heading loop. gain_code is to be written through cfg_we/cfg_data
// only while the unit is idle; the user must keep to this, as the unit itself
// does not enforce it.
module magnetometer_heading_calibrator_unit
	import mhc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_t out_data
);

	cmd_t cmd;
	stat_t stat;

	mhc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat(stat),
		.cmd(cmd)
	);

	mhc_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.cmd(cmd),
		.stat(stat),
		.out_data(out_data)
	);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a beat while busy");

	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.result_kind) |->
		(out_data.field_x == 0 && out_data.field_y == 0 &&
		out_data.field_z == 0 && out_data.heading_centideg == 0))
		else $error("acknowledgement carries data");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.heading_centideg < CENTIDEG_TURN))
		else $error("heading out of range");

endmodule

// ===== test/magnetometer_heading_calibrator_unit_test.sv =====
`timescale 1ns / 100ps

module magnetometer_heading_calibrator_unit_test
	import mhc_pkg::*;
;

	localparam longint TRACK_START = 2560000;
	localparam longint TURN = 64'd23592960;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	magnetometer_heading_calibrator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	in_t pending_beats[$];
	out_t expected_results[$];
	int send_idle_pct;
	int stall_pct;
	int mismatches;

	logic [2:0] gain;
	longint ofs[3];
	longint scl[3];
	longint trk_min[3];
	longint trk_max[3];

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic longint rdiv(longint num, longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint shr(longint v, int s);
		if (v >= 0) return v >>> s;
		return -1 - ((-1 - v) >>> s);
	endfunction

	function automatic longint clip24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic longint lsb_for(int axis, logic [2:0] code);
		case (code)
			3'd0, 3'd1: return axis == 2 ? 980 : 1100;
			3'd2: return axis == 2 ? 760 : 855;
			3'd3: return axis == 2 ? 600 : 670;
			3'd4: return axis == 2 ? 400 : 450;
			3'd5: return axis == 2 ? 255 : 400;
			3'd6: return axis == 2 ? 295 : 330;
			default: return axis == 2 ? 205 : 230;
		endcase
	endfunction

	function automatic longint arctan_step(int i);
		longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		return tab[i];
	endfunction

	function automatic longint compass_angle(longint fx, longint fy);
		longint x, y, z, nx, cd;
		x = fx * 256;
		y = fy * 256;
		z = 0;
		if (fx == 0 && fy == 0) return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = TURN / 2;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			if (y > 0) begin
				nx = x + shr(y, i);
				y = y - shr(x, i);
				z += arctan_step(i);
			end else begin
				nx = x - shr(y, i);
				y = y + shr(x, i);
				z -= arctan_step(i);
			end
			x = nx;
		end
		while (z < 0) z += TURN;
		while (z >= TURN) z -= TURN;
		cd = (z * 100 + 32768) / 65536;
		if (cd >= 36000) cd -= 36000;
		return cd;
	endfunction

	function automatic longint equalize(longint d, longint other);
		longint q;
		if (d <= 0) return 65535;
		q = ((d + other) * 4096 + d) / (2 * d);
		return q > 65535 ? 65535 : q;
	endfunction

	function automatic out_t calibrate(in_t b);
		out_t r;
		longint v[3];
		longint f[3];
		longint dx, dy;
		v[0] = rdiv(longint'(b.raw_x) * 25600, lsb_for(0, gain));
		v[1] = rdiv(longint'(b.raw_y) * 25600, lsb_for(1, gain));
		v[2] = rdiv(longint'(b.raw_z) * 25600, lsb_for(2, gain));
		r = '0;
		r.result_kind = 1'b1;
		case (b.action)
			ACT_MEASURE: begin
				for (int k = 0; k < 3; k++) f[k] = clip24(rdiv((v[k] - ofs[k]) * scl[k], 4096));
				r.result_kind = 1'b0;
				r.field_x = f[0][23:0];
				r.field_y = f[1][23:0];
				r.field_z = f[2][23:0];
				r.heading_centideg = 16'(compass_angle(f[0], f[1]));
			end
			ACT_CLEAR: begin
				for (int k = 0; k < 3; k++) begin
					trk_min[k] = TRACK_START;
					trk_max[k] = -TRACK_START;
				end
			end
			ACT_SAMPLE: begin
				for (int k = 0; k < 3; k++) begin
					if (v[k] < trk_min[k]) trk_min[k] = v[k];
					if (v[k] > trk_max[k]) trk_max[k] = v[k];
				end
			end
			ACT_FINISH: begin
				for (int k = 0; k < 3; k++) ofs[k] = clip24(shr(trk_max[k] + trk_min[k], 1));
				dx = trk_max[0] - trk_min[0];
				dy = trk_max[1] - trk_min[1];
				if (dx < 0) dx = 0;
				if (dy < 0) dy = 0;
				scl[0] = equalize(dx, dy);
				scl[1] = equalize(dy, dx);
				scl[2] = 4096;
			end
			ACT_LOAD: begin
				ofs[0] = b.load_offset_x;
				ofs[1] = b.load_offset_y;
				ofs[2] = b.load_offset_z;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic in_t random_beat(logic [2:0] act);
		in_t b;
		b.action = act;
		b.raw_x = 16'($urandom);
		b.raw_y = 16'($urandom);
		b.raw_z = 16'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			b.raw_x = 16'($signed($urandom_range(0, 400)) - 200);
			b.raw_y = 16'($signed($urandom_range(0, 400)) - 200);
		end
		b.load_offset_x = 24'($urandom);
		b.load_offset_y = 24'($urandom);
		b.load_offset_z = 24'($urandom);
		if ($urandom_range(0, 1)) begin
			b.load_offset_x = 24'($signed($urandom_range(0, 200000)) - 100000);
			b.load_offset_y = 24'($signed($urandom_range(0, 200000)) - 100000);
			b.load_offset_z = 24'($signed($urandom_range(0, 200000)) - 100000);
		end
		return b;
	endfunction

	function automatic in_t fixed_beat(logic [2:0] act, logic [15:0] x, logic [15:0] y,
			logic [15:0] z, logic [23:0] o);
		in_t b;
		b.action = act;
		b.raw_x = x;
		b.raw_y = y;
		b.raw_z = z;
		b.load_offset_x = o;
		b.load_offset_y = ~o;
		b.load_offset_z = o;
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				expected_results.push_back(calibrate(in_data));
			end
			if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_beats.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", out_data);
				end else if (out_data !== expected_results[0]) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected %p", expected_results[0]);
						$display("          actual   %p", out_data);
					end
					void'(expected_results.pop_front());
				end else begin
					void'(expected_results.pop_front());
				end
			end
			out_ready <= $urandom_range(0, 99) >= stall_pct;
		end
	end

	task automatic drain();
		wait (pending_beats.size() == 0 && !in_valid);
		@(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_gain(logic [2:0] code);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= code;
		@(posedge clk);
		cfg_we <= 1'b0;
		gain = code;
	endtask

	task automatic queue_random(int count);
		for (int n = 0; n < count; n++) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				pending_beats.push_back(random_beat(ACT_CLEAR));
				for (int s = $urandom_range(1, 6); s > 0; s--)
					pending_beats.push_back(random_beat(ACT_SAMPLE));
				pending_beats.push_back(random_beat(ACT_FINISH));
			end else if (pick < 60) begin
				pending_beats.push_back(random_beat(ACT_MEASURE));
			end else if (pick < 75) begin
				pending_beats.push_back(random_beat(ACT_SAMPLE));
			end else if (pick < 82) begin
				pending_beats.push_back(random_beat(ACT_LOAD));
			end else if (pick < 88) begin
				pending_beats.push_back(random_beat(ACT_FINISH));
			end else if (pick < 93) begin
				pending_beats.push_back(random_beat(ACT_CLEAR));
			end else begin
				pending_beats.push_back(random_beat(3'($urandom_range(5, 7))));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		gain = 3'd1;
		for (int k = 0; k < 3; k++) begin
			ofs[k] = 0;
			scl[k] = 4096;
			trk_min[k] = TRACK_START;
			trk_max[k] = -TRACK_START;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_beats.push_back(fixed_beat(ACT_MEASURE, 16'd0, 16'd0, 16'd0, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_MEASURE, 16'h7FFF, 16'h8000, 16'h7FFF, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_MEASURE, 16'h8000, 16'h7FFF, 16'h8000, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_MEASURE, 16'h8000, 16'd0, 16'hFFFF, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_MEASURE, 16'd0, 16'hFFFF, 16'd1, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_FINISH, 16'd0, 16'd0, 16'd0, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_MEASURE, 16'd5, 16'hFFFB, 16'd3, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_SAMPLE, 16'd100, 16'd100, 16'd100, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_FINISH, 16'd0, 16'd0, 16'd0, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_MEASURE, 16'd300, 16'd1, 16'd0, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
		pending_beats.push_back(fixed_beat(ACT_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_SAMPLE, 16'h7FFF, 16'hFF00, 16'h7FFF, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_FINISH, 16'd0, 16'd0, 16'd0, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_MEASURE, 16'h7FFF, 16'h8000, 16'd0, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_LOAD, 16'd0, 16'd0, 16'd0, 24'h7FFFFF));
		pending_beats.push_back(fixed_beat(ACT_MEASURE, 16'h8000, 16'h8000, 16'h8000, 24'd0));
		pending_beats.push_back(fixed_beat(ACT_LOAD, 16'd0, 16'd0, 16'd0, 24'h800000));
		pending_beats.push_back(fixed_beat(ACT_MEASURE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'd0));
		pending_beats.push_back(fixed_beat(3'd5, 16'd1, 16'd1, 16'd1, 24'd1));
		pending_beats.push_back(fixed_beat(3'd6, 16'd1, 16'd1, 16'd1, 24'd1));
		pending_beats.push_back(fixed_beat(3'd7, 16'd1, 16'd1, 16'd1, 24'd1));
		pending_beats.push_back(fixed_beat(ACT_LOAD, 16'd0, 16'd0, 16'd0, 24'd0));
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			write_gain(phase == 0 ? 3'd0 : phase == 7 ? 3'd7 : 3'($urandom_range(0, 7)));
			case (phase % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 59; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 59; end
				default: begin send_idle_pct = 32; stall_pct = 32; end
			endcase
			queue_random(110);
			drain();
		end

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS magnetometer_heading_calibrator_unit");
		end else begin
			$display("FAIL magnetometer_heading_calibrator_unit");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("FAIL magnetometer_heading_calibrator_unit");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mhc_pkg.sv
rtl/mhc_div.sv
rtl/mhc_ctrl.sv
rtl/mhc_datapath.sv
rtl/magnetometer_heading_calibrator_unit.sv
test/magnetometer_heading_calibrator_unit_test.sv
